### hw/rtl/cmpr_pkg.sv
// Shared types and constants of the CAN multi-frame packet reassembler.
package cmpr_pkg;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned NodeW      = 5;
  localparam int unsigned DestLsb    = 16;
  localparam int unsigned SrcLsb     = 22;
  localparam int unsigned LenW       = 17;
  localparam logic [3:0]  MaxBytes   = 4'd8;

  localparam logic [7:0] HeaderReset   = 8'hAA;
  localparam logic [7:0] TailReset     = 8'h55;
  localparam logic [7:0] LongTypeReset = 8'hC4;

  localparam logic [LenW-1:0] ShortExtra = LenW'(5);
  localparam logic [LenW-1:0] LongExtra  = LenW'(6);

  typedef enum logic [3:0] {
    StPartial  = 4'd0,
    StOk       = 4'd1,
    StRequest  = 4'd2,
    StHeader   = 4'd3,
    StDest     = 4'd4,
    StSrc      = 4'd5,
    StOverrun  = 4'd6,
    StTail     = 4'd7,
    StChecksum = 4'd8,
    StShort    = 4'd9
  } cmpr_status_e;

  typedef enum logic [1:0] {
    RegHeader   = 2'd0,
    RegTail     = 2'd1,
    RegLongType = 2'd2
  } cmpr_reg_e;

  typedef struct packed {
    logic [28:0] frame_id;
    logic [3:0]  frame_len;
    logic [7:0]  byte0;
    logic [7:0]  byte1;
    logic [7:0]  byte2;
    logic [7:0]  byte3;
    logic [7:0]  byte4;
    logic [7:0]  byte5;
    logic [7:0]  byte6;
    logic [7:0]  byte7;
  } cmpr_frame_t;

  typedef struct packed {
    cmpr_status_e     status;
    logic [NodeW-1:0] source_node;
    logic [NodeW-1:0] dest_node;
    logic [3:0]       byte_count;
    logic [7:0]       out0;
    logic [7:0]       out1;
    logic [7:0]       out2;
    logic [7:0]       out3;
    logic [7:0]       out4;
    logic [7:0]       out5;
    logic [7:0]       out6;
    logic [7:0]       out7;
  } cmpr_result_t;

  typedef struct packed {
    logic [1:0] reg_index;
    logic [7:0] wdata;
  } cmpr_cfg_t;

  typedef struct packed {
    logic [7:0] header;
    logic [7:0] tail;
    logic [7:0] long_type;
  } cmpr_cfg_regs_t;

  // Classified frame handed from front to back
  typedef struct packed {
    logic             is_req;
    logic             hdr_ok;
    logic             short_err;
    logic [NodeW-1:0] src;
    logic [NodeW-1:0] dst;
    logic [3:0]       len;
    logic [7:0][7:0]  data;
    logic [7:0]       last_byte;
    logic [LenW-1:0]  needed;
  } cmpr_item_t;

endpackage

### hw/rtl/cmpr_stream_if.sv
// Valid/ready channel carrying one payload per transaction.
interface cmpr_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### hw/rtl/cmpr_front.sv
// Front end: accepts frames and classifies them for the packet engine.
module cmpr_front (
  input  cmpr_pkg::cmpr_cfg_regs_t regs_i,
  cmpr_stream_if.sink              frame_i,
  input  logic                     full_i,
  output logic                     push_o,
  output cmpr_pkg::cmpr_item_t     item_o
);

  cmpr_pkg::cmpr_frame_t f;
  logic [7:0][7:0]       raw;
  logic [3:0]            len;
  logic [2:0]            last_idx;
  logic                  is_long;

  assign f             = frame_i.data;
  assign frame_i.ready = !full_i;
  assign push_o        = frame_i.valid && !full_i;

  assign raw = {f.byte7, f.byte6, f.byte5, f.byte4, f.byte3, f.byte2, f.byte1, f.byte0};

  always_comb begin
    len      = (f.frame_len > cmpr_pkg::MaxBytes) ? cmpr_pkg::MaxBytes : f.frame_len;
    last_idx = 3'(len - 4'd1);
    is_long  = (len >= 4'd2) && (raw[1] == regs_i.long_type);

    item_o.is_req    = (len == 4'd0);
    item_o.hdr_ok    = (raw[0] == regs_i.header);
    item_o.short_err = (len < 4'd3) || (is_long && (len < 4'd4));
    item_o.src       = f.frame_id[cmpr_pkg::SrcLsb +: cmpr_pkg::NodeW];
    item_o.dst       = f.frame_id[cmpr_pkg::DestLsb +: cmpr_pkg::NodeW];
    item_o.len       = len;
    item_o.last_byte = (len == 4'd0) ? 8'h00 : raw[last_idx];
    for (int j = 0; j < 8; j++) begin
      item_o.data[j] = (4'(j) < len) ? raw[j] : 8'h00;
    end
    if (is_long) begin
      item_o.needed = cmpr_pkg::LenW'({raw[2], raw[3]}) + cmpr_pkg::LongExtra;
    end else begin
      item_o.needed = cmpr_pkg::LenW'(raw[2]) + cmpr_pkg::ShortExtra;
    end
  end

endmodule

### hw/rtl/cmpr_fifo.sv
// Small queue decoupling the frame front end from the packet engine.
module cmpr_fifo #(
  parameter int unsigned Depth = cmpr_pkg::QueueDepth,
  parameter type T = logic
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  T     data_i,
  output logic full_o,
  input  logic pop_i,
  output T     data_o,
  output logic empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  T                mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

### hw/rtl/cmpr_back.sv
// Packet engine: tracks the packet in progress and registers one result per frame.
module cmpr_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [7:0]           tail_i,
  input  logic                 empty_i,
  input  cmpr_pkg::cmpr_item_t item_i,
  output logic                 pop_o,
  cmpr_stream_if.source        result_o
);

  localparam int unsigned LenW  = cmpr_pkg::LenW;
  localparam int unsigned NodeW = cmpr_pkg::NodeW;

  logic             recv_q, recv_d;
  logic [NodeW-1:0] held_dst_q, held_dst_d;
  logic [NodeW-1:0] held_src_q, held_src_d;
  logic [LenW-1:0]  rem_q, rem_d;
  logic [7:0]       sum_q, sum_d;
  logic [7:0]       seen_q, seen_d;

  logic                  out_valid_q, out_valid_d;
  cmpr_pkg::cmpr_result_t out_q, out_d;

  cmpr_pkg::cmpr_status_e status;
  logic                   opening;
  logic [LenW-1:0]        base_rem;
  logic [LenW-1:0]        len_w;
  logic [7:0]             acc_sum;
  logic [7:0]             acc_seen;

  assign pop_o          = !empty_i && (!out_valid_q || result_o.ready);
  assign result_o.valid = out_valid_q;
  assign result_o.data  = out_q;
  assign len_w          = LenW'(item_i.len);

  // per-byte checksum accumulation and checksum-byte capture over the remaining packet window
  always_comb begin
    opening  = !recv_q;
    base_rem = recv_q ? rem_q : item_i.needed;
    acc_sum  = recv_q ? sum_q : 8'h00;
    acc_seen = recv_q ? seen_q : 8'h00;
    for (int j = 0; j < 8; j++) begin
      if (4'(j) < item_i.len) begin
        if ((base_rem >= LenW'(j + 3)) && !(opening && (j == 0))) begin
          acc_sum = acc_sum + item_i.data[j];
        end
        if (base_rem == LenW'(j + 2)) begin
          acc_seen = item_i.data[j];
        end
      end
    end
  end

  always_comb begin
    recv_d     = recv_q;
    held_dst_d = held_dst_q;
    held_src_d = held_src_q;
    rem_d      = rem_q;
    sum_d      = sum_q;
    seen_d     = seen_q;
    status     = cmpr_pkg::StPartial;
    if (item_i.is_req) begin
      status = cmpr_pkg::StRequest;
    end else if (!recv_q && !item_i.hdr_ok) begin
      status = cmpr_pkg::StHeader;
    end else if (!recv_q && item_i.short_err) begin
      status = cmpr_pkg::StShort;
    end else if (recv_q && (item_i.dst != held_dst_q)) begin
      status = cmpr_pkg::StDest;
      recv_d = 1'b0;
    end else if (recv_q && (item_i.src != held_src_q)) begin
      status = cmpr_pkg::StSrc;
      recv_d = 1'b0;
    end else if (len_w > base_rem) begin
      status = cmpr_pkg::StOverrun;
      recv_d = 1'b0;
    end else if (len_w == base_rem) begin
      if (item_i.last_byte != tail_i) begin
        status = cmpr_pkg::StTail;
      end else if (acc_sum != acc_seen) begin
        status = cmpr_pkg::StChecksum;
      end else begin
        status = cmpr_pkg::StOk;
      end
      recv_d = 1'b0;
    end else begin
      recv_d     = 1'b1;
      held_dst_d = item_i.dst;
      held_src_d = item_i.src;
      rem_d      = base_rem - len_w;
      sum_d      = acc_sum;
      seen_d     = acc_seen;
    end
    if (!recv_d) begin
      held_dst_d = '0;
      held_src_d = '0;
      rem_d      = '0;
      sum_d      = '0;
      seen_d     = '0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (pop_o) begin
      out_valid_d       = 1'b1;
      out_d.status      = status;
      out_d.source_node = item_i.src;
      out_d.dest_node   = item_i.dst;
      out_d.byte_count  = item_i.len;
      out_d.out0        = item_i.data[0];
      out_d.out1        = item_i.data[1];
      out_d.out2        = item_i.data[2];
      out_d.out3        = item_i.data[3];
      out_d.out4        = item_i.data[4];
      out_d.out5        = item_i.data[5];
      out_d.out6        = item_i.data[6];
      out_d.out7        = item_i.data[7];
    end else if (result_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      recv_q      <= 1'b0;
      held_dst_q  <= '0;
      held_src_q  <= '0;
      rem_q       <= '0;
      sum_q       <= '0;
      seen_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (pop_o) begin
        recv_q     <= recv_d;
        held_dst_q <= held_dst_d;
        held_src_q <= held_src_d;
        rem_q      <= rem_d;
        sum_q      <= sum_d;
        seen_q     <= seen_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  a_idle_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !recv_q |-> (rem_q == '0 && sum_q == '0 && seen_q == '0 && held_dst_q == '0))
    else $error("idle with stale packet state");

  a_busy_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    recv_q |-> (rem_q != '0))
    else $error("packet in progress with nothing remaining");

  a_req_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && item_i.is_req) |=> (recv_q == $past(recv_q) && rem_q == $past(rem_q)))
    else $error("request frame disturbed packet state");

  a_pop_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> out_valid_q)
    else $error("frame taken without a result");

endmodule

### hw/rtl/can_multiframe_packet_reassembler_top.sv
// Top level of the CAN multi-frame packet reassembler.
// Takes one received CAN frame per transaction and returns exactly one result per frame,
// in order, carrying the frame's bytes and a packet status. Sustained rate is one frame
// per clock while results are taken; a frame's result is registered in the queue entry,
// then in the result register, before it is presented. The rate is set by the packet
// engine, whose eight-byte checksum add chain is the longest path. Configuration writes are
// always accepted and must only be made while no frame is in flight.
module can_multiframe_packet_reassembler_top #(
  parameter int unsigned QueueDepth = cmpr_pkg::QueueDepth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  cmpr_stream_if.sink   cfg_i,
  cmpr_stream_if.sink   frame_i,
  cmpr_stream_if.source result_o
);

  cmpr_pkg::cmpr_cfg_regs_t regs_q, regs_d;
  cmpr_pkg::cmpr_cfg_t      cfg;
  cmpr_pkg::cmpr_item_t     push_item;
  cmpr_pkg::cmpr_item_t     pop_item;
  logic                     push;
  logic                     pop;
  logic                     full;
  logic                     empty;

  assign cfg         = cfg_i.data;
  assign cfg_i.ready = 1'b1;

  always_comb begin
    regs_d = regs_q;
    if (cfg_i.valid) begin
      unique case (cfg.reg_index)
        cmpr_pkg::RegHeader:   regs_d.header    = cfg.wdata;
        cmpr_pkg::RegTail:     regs_d.tail      = cfg.wdata;
        cmpr_pkg::RegLongType: regs_d.long_type = cfg.wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q.header    <= cmpr_pkg::HeaderReset;
      regs_q.tail      <= cmpr_pkg::TailReset;
      regs_q.long_type <= cmpr_pkg::LongTypeReset;
    end else begin
      regs_q <= regs_d;
    end
  end

  cmpr_front u_front (
    .regs_i  (regs_q),
    .frame_i (frame_i),
    .full_i  (full),
    .push_o  (push),
    .item_o  (push_item)
  );

  cmpr_fifo #(
    .Depth (QueueDepth),
    .T     (cmpr_pkg::cmpr_item_t)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_item),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (pop_item),
    .empty_o (empty)
  );

  cmpr_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .tail_i   (regs_q.tail),
    .empty_i  (empty),
    .item_i   (pop_item),
    .pop_o    (pop),
    .result_o (result_o)
  );

endmodule

### test/can_multiframe_packet_reassembler_top_tb.sv
// Self-checking testbench for the CAN multi-frame packet reassembler top level.
module can_multiframe_packet_reassembler_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ItemsPerPhase = 240;
  localparam int unsigned NumPhases     = 6;
  localparam int unsigned StuckLimit    = 2000;
  localparam int unsigned HoldCycles    = 300;

  typedef struct packed {
    logic                   pinned;
    cmpr_pkg::cmpr_status_e st;
    cmpr_pkg::cmpr_frame_t  frm;
  } frame_row_t;

  // Directed frames under the reset register values
  localparam int unsigned NumDirected = 21;
  localparam frame_row_t DirectedTab [NumDirected] = '{
    {1'b1, cmpr_pkg::StRequest,  29'h1FFF_FFFF, 4'd0,  64'hFFFF_FFFF_FFFF_FFFF},
    {1'b1, cmpr_pkg::StHeader,   29'h000_0000,  4'd8,  64'h00FF_00FF_00FF_00FF},
    {1'b1, cmpr_pkg::StShort,    29'h10C7_1234, 4'd2,  64'hAA01_0000_0000_0000},
    {1'b1, cmpr_pkg::StShort,    29'h10C7_1234, 4'd3,  64'hAAC4_0000_0000_0000},
    {1'b1, cmpr_pkg::StOk,       29'h10C7_1234, 4'd5,  64'hAA01_0001_55FF_FFFF},
    {1'b1, cmpr_pkg::StTail,     29'h10C7_1234, 4'd5,  64'hAA01_0001_5600_0000},
    {1'b1, cmpr_pkg::StChecksum, 29'h10C7_1234, 4'd5,  64'hAA01_0002_5500_0000},
    {1'b1, cmpr_pkg::StOverrun,  29'h10C7_1234, 4'd6,  64'hAA01_0001_5500_0000},
    {1'b1, cmpr_pkg::StOk,       29'h10C7_1234, 4'd6,  64'hAAC4_0000_C455_0000},
    {1'b1, cmpr_pkg::StHeader,   29'h1FFF_FFFF, 4'd15, 64'hFFFF_FFFF_FFFF_FFFF},
    {1'b1, cmpr_pkg::StPartial,  29'h10C7_1234, 4'd8,  64'hAA02_0A11_2233_4455},
    {1'b1, cmpr_pkg::StRequest,  29'h10C7_1234, 4'd0,  64'h0000_0000_0000_0000},
    {1'b1, cmpr_pkg::StDest,     29'h10C8_1234, 4'd8,  64'h0123_4567_89AB_CDEF},
    {1'b1, cmpr_pkg::StPartial,  29'h10C7_1234, 4'd8,  64'hAA02_0A11_2233_4455},
    {1'b1, cmpr_pkg::StSrc,      29'h1107_1234, 4'd8,  64'hFEDC_BA98_7654_3210},
    {1'b1, cmpr_pkg::StPartial,  29'h10C7_1234, 4'd8,  64'hAA02_0A11_2233_4455},
    {1'b0, cmpr_pkg::StPartial,  29'h10C7_5678, 4'd7,  64'h6677_8899_AA3E_5500},
    {1'b1, cmpr_pkg::StPartial,  29'h00C7_0000, 4'd8,  64'hAAC4_FFFF_0000_0000},
    {1'b1, cmpr_pkg::StPartial,  29'h00C7_FFFF, 4'd9,  64'hFFFF_FFFF_FFFF_FFFF},
    {1'b1, cmpr_pkg::StDest,     29'h000_0000,  4'd1,  64'h0000_0000_0000_0000},
    {1'b1, cmpr_pkg::StShort,    29'h10C7_1234, 4'd1,  64'hAAFF_FFFF_FFFF_FFFF}
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  always #5 clk_i = ~clk_i;

  cmpr_stream_if #(.T(cmpr_pkg::cmpr_cfg_t))    cfg_if ();
  cmpr_stream_if #(.T(cmpr_pkg::cmpr_frame_t))  frame_if ();
  cmpr_stream_if #(.T(cmpr_pkg::cmpr_result_t)) res_if ();

  can_multiframe_packet_reassembler_top u_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_if),
    .frame_i  (frame_if),
    .result_o (res_if)
  );

  // Register copies
  logic [7:0] hdr_byte  = cmpr_pkg::HeaderReset;
  logic [7:0] tail_byte = cmpr_pkg::TailReset;
  logic [7:0] long_byte = cmpr_pkg::LongTypeReset;

  // Packet tracking
  logic                       pkt_open = 1'b0;
  logic [cmpr_pkg::NodeW-1:0] pkt_dest = '0;
  logic [cmpr_pkg::NodeW-1:0] pkt_src  = '0;
  int unsigned                pkt_got  = 0;
  int unsigned                pkt_need = 0;
  logic [7:0]                 pkt_sum  = '0;
  logic [7:0]                 pkt_chk  = '0;

  frame_row_t             tx_frames_q [$];
  cmpr_pkg::cmpr_result_t reassembly_q [$];
  int unsigned            err_cnt       = 0;
  int unsigned            stuck_cycles  = 0;
  bit                     hold_request  = 1'b0;

  function automatic void drop_packet();
    pkt_open = 1'b0;
    pkt_dest = '0;
    pkt_src  = '0;
    pkt_got  = 0;
    pkt_need = 0;
    pkt_sum  = '0;
    pkt_chk  = '0;
  endfunction

  function automatic cmpr_pkg::cmpr_status_e absorb_bytes(input logic [7:0] b [8],
                                                          input int unsigned len);
    int unsigned            pos;
    cmpr_pkg::cmpr_status_e st;
    for (int j = 0; j < int'(len); j++) begin
      pos = pkt_got + j;
      if (pos >= 1 && pos + 3 <= pkt_need) pkt_sum = pkt_sum + b[j];
      if (pos + 2 == pkt_need) pkt_chk = b[j];
    end
    pkt_got = (pkt_got + len) & 32'h1FFFF;
    if (pkt_got > pkt_need) begin
      drop_packet();
      return cmpr_pkg::StOverrun;
    end
    if (pkt_got == pkt_need) begin
      if (b[len-1] != tail_byte) st = cmpr_pkg::StTail;
      else if (pkt_sum != pkt_chk) st = cmpr_pkg::StChecksum;
      else st = cmpr_pkg::StOk;
      drop_packet();
      return st;
    end
    return cmpr_pkg::StPartial;
  endfunction

  function automatic cmpr_pkg::cmpr_result_t reassemble_frame(input cmpr_pkg::cmpr_frame_t f);
    logic [7:0]                 b [8];
    int unsigned                len;
    logic [cmpr_pkg::NodeW-1:0] src;
    logic [cmpr_pkg::NodeW-1:0] dst;
    logic                       is_long;
    cmpr_pkg::cmpr_status_e     st;
    cmpr_pkg::cmpr_result_t     r;
    b   = '{f.byte0, f.byte1, f.byte2, f.byte3, f.byte4, f.byte5, f.byte6, f.byte7};
    len = f.frame_len;
    if (len > cmpr_pkg::MaxBytes) len = cmpr_pkg::MaxBytes;
    src = f.frame_id[cmpr_pkg::SrcLsb +: cmpr_pkg::NodeW];
    dst = f.frame_id[cmpr_pkg::DestLsb +: cmpr_pkg::NodeW];
    if (len == 0) begin
      st = cmpr_pkg::StRequest;
    end else if (!pkt_open) begin
      if (b[0] != hdr_byte) begin
        st = cmpr_pkg::StHeader;
      end else begin
        is_long = (len >= 2) && (b[1] == long_byte);
        if (len < 3 || (is_long && len < 4)) begin
          st = cmpr_pkg::StShort;
        end else begin
          drop_packet();
          pkt_open = 1'b1;
          pkt_dest = dst;
          pkt_src  = src;
          pkt_need = is_long ? 32'({b[2], b[3]}) + 32'(cmpr_pkg::LongExtra)
                             : 32'(b[2]) + 32'(cmpr_pkg::ShortExtra);
          st = absorb_bytes(b, len);
        end
      end
    end else if (dst != pkt_dest) begin
      drop_packet();
      st = cmpr_pkg::StDest;
    end else if (src != pkt_src) begin
      drop_packet();
      st = cmpr_pkg::StSrc;
    end else begin
      st = absorb_bytes(b, len);
    end
    for (int j = 0; j < 8; j++) if (j >= int'(len)) b[j] = '0;
    r.status      = st;
    r.source_node = src;
    r.dest_node   = dst;
    r.byte_count  = 4'(len);
    r.out0 = b[0];
    r.out1 = b[1];
    r.out2 = b[2];
    r.out3 = b[3];
    r.out4 = b[4];
    r.out5 = b[5];
    r.out6 = b[6];
    r.out7 = b[7];
    return r;
  endfunction

  function automatic frame_row_t frame_of(input logic [28:0] id, input logic [3:0] len,
                                          input logic [7:0] fb [8]);
    frame_row_t row;
    row = '0;
    row.frm.frame_id  = id;
    row.frm.frame_len = len;
    row.frm.byte0 = fb[0];
    row.frm.byte1 = fb[1];
    row.frm.byte2 = fb[2];
    row.frm.byte3 = fb[3];
    row.frm.byte4 = fb[4];
    row.frm.byte5 = fb[5];
    row.frm.byte6 = fb[6];
    row.frm.byte7 = fb[7];
    return row;
  endfunction

  function automatic int unsigned draw_gap(ref bit calm);
    if ($urandom_range(0, 31) == 0) calm = !calm;
    return calm ? 0 : $urandom_range(0, 8);
  endfunction

  // One packet split into frames, with occasional disruption, or a single noise frame
  task automatic queue_packet();
    logic [7:0]                 pkt [$];
    logic [7:0]                 fb [8];
    logic [7:0]                 chk;
    logic [7:0]                 len_hi;
    logic [7:0]                 len_lo;
    logic [7:0]                 ptype;
    logic [28:0]                fid;
    logic [cmpr_pkg::NodeW-1:0] src;
    logic [cmpr_pkg::NodeW-1:0] dst;
    int unsigned                need;
    int unsigned                pos;
    int unsigned                lo;
    int unsigned                rem;
    int unsigned                chunk;
    int unsigned                flen;
    int unsigned                mode;
    bit                         long_pkt;
    bit                         first;
    if ($urandom_range(0, 9) == 0) begin
      for (int j = 0; j < 8; j++) fb[j] = 8'($urandom());
      if ($urandom_range(0, 1) == 0) fb[0] = hdr_byte;
      tx_frames_q.push_back(frame_of(29'($urandom()), 4'($urandom_range(0, 15)), fb));
      return;
    end
    long_pkt = ($urandom_range(0, 3) == 0);
    src  = cmpr_pkg::NodeW'($urandom());
    dst  = cmpr_pkg::NodeW'($urandom());
    mode = $urandom_range(0, 19);
    pkt.push_back(hdr_byte);
    if (long_pkt) begin
      len_hi = ($urandom_range(0, 29) == 0) ? 8'($urandom_range(0, 1)) : 8'h00;
      len_lo = ($urandom_range(0, 19) == 0) ? 8'($urandom_range(0, 255))
                                            : 8'($urandom_range(0, 24));
      pkt.push_back(long_byte);
      pkt.push_back(len_hi);
      pkt.push_back(len_lo);
      need = 32'({len_hi, len_lo}) + 6;
    end else begin
      ptype = 8'($urandom());
      if (ptype == long_byte) ptype = ~ptype;
      len_lo = ($urandom_range(0, 19) == 0) ? 8'($urandom_range(0, 255))
                                            : 8'($urandom_range(0, 24));
      pkt.push_back(ptype);
      pkt.push_back(len_lo);
      need = 32'(len_lo) + 5;
    end
    while (pkt.size() < need - 2) pkt.push_back(8'($urandom()));
    chk = '0;
    for (int i = 1; i <= int'(need) - 3; i++) chk = chk + pkt[i];
    pkt.push_back(chk);
    pkt.push_back(tail_byte);
    if ($urandom_range(0, 9) == 0) pkt[need - 1 - $urandom_range(0, 1)] ^= 8'(1 << $urandom_range(0, 7));

    pos   = 0;
    first = 1'b1;
    while (pos < need) begin
      lo    = first ? (long_pkt ? 4 : 3) : 1;
      rem   = need - pos;
      chunk = $urandom_range(lo, rem < 8 ? rem : 8);
      for (int j = 0; j < 8; j++) fb[j] = (j < int'(chunk)) ? pkt[pos + j] : 8'($urandom());
      flen = chunk;
      if (mode == 3 && pos + chunk == need && chunk < 8) flen = $urandom_range(chunk + 1, 8);
      if (flen == 8 && $urandom_range(0, 3) == 0) flen = $urandom_range(9, 15);
      fid = 29'($urandom());
      fid[cmpr_pkg::SrcLsb +: cmpr_pkg::NodeW]  = src;
      fid[cmpr_pkg::DestLsb +: cmpr_pkg::NodeW] = dst;
      if (!first && mode == 1 && $urandom_range(0, 3) == 0) begin
        fid[cmpr_pkg::DestLsb +: cmpr_pkg::NodeW] = dst ^ cmpr_pkg::NodeW'($urandom_range(1, 31));
        mode = 99;
      end
      if (!first && mode == 2 && $urandom_range(0, 3) == 0) begin
        fid[cmpr_pkg::SrcLsb +: cmpr_pkg::NodeW] = src ^ cmpr_pkg::NodeW'($urandom_range(1, 31));
        mode = 99;
      end
      tx_frames_q.push_back(frame_of(fid, 4'(flen), fb));
      if (!first && mode == 0 && $urandom_range(0, 2) == 0) begin
        tx_frames_q.push_back(frame_of(29'($urandom()), 4'd0, fb));
        mode = 99;
      end
      pos   = pos + chunk;
      first = 1'b0;
    end
  endtask

  task automatic load_regs(input logic [7:0] h, input logic [7:0] t, input logic [7:0] l);
    cmpr_pkg::cmpr_reg_e idx [3];
    logic [7:0]          vals [3];
    idx  = '{cmpr_pkg::RegHeader, cmpr_pkg::RegTail, cmpr_pkg::RegLongType};
    vals = '{h, t, l};
    for (int i = 0; i < 3; i++) begin
      cfg_if.valid <= 1'b1;
      cfg_if.data  <= '{reg_index: idx[i], wdata: vals[i]};
      do @(posedge clk_i); while (!cfg_if.ready);
    end
    cfg_if.valid <= 1'b0;
    hdr_byte  = h;
    tail_byte = t;
    long_byte = l;
  endtask

  task automatic send_frames();
    frame_row_t             row;
    cmpr_pkg::cmpr_result_t due;
    int unsigned            gap;
    bit                     calm;
    calm = 1'b0;
    while (tx_frames_q.size() > 0) begin
      row = tx_frames_q.pop_front();
      frame_if.valid <= 1'b1;
      frame_if.data  <= row.frm;
      do @(posedge clk_i); while (!frame_if.ready);
      due = reassemble_frame(row.frm);
      if (row.pinned) due.status = row.st;
      reassembly_q.push_back(due);
      gap = draw_gap(calm);
      if (gap > 0 || tx_frames_q.size() == 0) frame_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    while (reassembly_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic check_result(input cmpr_pkg::cmpr_result_t act);
    cmpr_pkg::cmpr_result_t due;
    logic [63:0]            eb;
    logic [63:0]            ab;
    if (reassembly_q.size() == 0) begin
      $error("result transaction with nothing pending, status %0d", act.status);
      err_cnt++;
      return;
    end
    due = reassembly_q.pop_front();
    if (act.status !== due.status) begin
      $error("status: expected %0d, actual %0d", due.status, act.status);
      err_cnt++;
    end
    if (act.source_node !== due.source_node) begin
      $error("source_node: expected %0d, actual %0d", due.source_node, act.source_node);
      err_cnt++;
    end
    if (act.dest_node !== due.dest_node) begin
      $error("dest_node: expected %0d, actual %0d", due.dest_node, act.dest_node);
      err_cnt++;
    end
    if (act.byte_count !== due.byte_count) begin
      $error("byte_count: expected %0d, actual %0d", due.byte_count, act.byte_count);
      err_cnt++;
    end
    eb = due[63:0];
    ab = act[63:0];
    for (int i = 0; i < 8; i++) begin
      if (ab[63-8*i -: 8] !== eb[63-8*i -: 8]) begin
        $error("out%0d: expected %02h, actual %02h", i, eb[63-8*i -: 8], ab[63-8*i -: 8]);
        err_cnt++;
      end
    end
  endtask

  // Result sink with random back-pressure and one long hold
  initial begin
    int unsigned gap;
    bit          calm;
    calm = 1'b0;
    res_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        res_if.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end
      gap = draw_gap(calm);
      if (gap > 0) begin
        res_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk_i); while (!res_if.valid);
    end
  end

  always @(posedge clk_i) begin
    if (res_if.valid && res_if.ready) check_result(res_if.data);
    if (!rst_ni || (frame_if.valid && frame_if.ready) || (res_if.valid && res_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= StuckLimit) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    rst_ni         <= 1'b0;
    cfg_if.valid   <= 1'b0;
    cfg_if.data    <= '0;
    frame_if.valid <= 1'b0;
    frame_if.data  <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < int'(NumDirected); i++) tx_frames_q.push_back(DirectedTab[i]);
    send_frames();
    wait_drained();

    for (int phase = 0; phase < int'(NumPhases); phase++) begin
      case (phase)
        0: load_regs(8'h00, 8'hFF, 8'h00);
        1: load_regs(8'hFF, 8'h00, 8'hFF);
        5: load_regs(cmpr_pkg::HeaderReset, cmpr_pkg::TailReset, cmpr_pkg::LongTypeReset);
        default: load_regs(8'($urandom()), 8'($urandom()), 8'($urandom()));
      endcase
      if (phase == 2) hold_request = 1'b1;
      while (tx_frames_q.size() < ItemsPerPhase) queue_packet();
      send_frames();
      wait_drained();
    end

    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/cmpr_pkg.sv
hw/rtl/cmpr_stream_if.sv
hw/rtl/cmpr_front.sv
hw/rtl/cmpr_fifo.sv
hw/rtl/cmpr_back.sv
hw/rtl/can_multiframe_packet_reassembler_top.sv
test/can_multiframe_packet_reassembler_top_tb.sv
